FILE: rtl/core/sliding_window_median_defines.svh
// Assertion macros for the sliding window median block.
// Used by the top level only; no other dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted.
`define SWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Same check, kept as a separate name for handshake-related properties.
`define SWM_ASSERT_HS(lbl, prop, msg) \
	`SWM_ASSERT(lbl, prop, msg)
`else
`define SWM_ASSERT(lbl, prop, msg)
`define SWM_ASSERT_HS(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/swm_pkg.sv
// Shared types and constants for the sliding window median block.
// No dependencies; imported by swm_ctrl, swm_dp and the top level.
package swm_pkg;

	localparam int DATA_W     = 16;
	localparam int WINDOW_DEF = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_CAND,
		ST_CLOAD,
		ST_SCAN,
		ST_OUT
	} swm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;    // latch the incoming sample
		logic wr;      // write sample into the window, advance ring pointer
		logic cand;    // read candidate entry, clear rank counters
		logic cload;   // latch candidate, start scan reads
		logic scan;    // scan window, count entries below / at candidate
		logic out_ld;  // load the result register
	} swm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;  // all compares for current candidate finished
		logic last_cand;  // current candidate is the last window entry
	} swm_sts_t;

endpackage

FILE: rtl/core/swm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module swm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/swm_ctrl.sv
// Controller FSM for the sliding window median block.
// Depends on swm_pkg; drives swm_dp through swm_cmd_t.
module swm_ctrl import swm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  swm_sts_t sts,
	output swm_cmd_t cmd
);

	swm_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_CAND;
			ST_CAND:  state_d = ST_CLOAD;
			ST_CLOAD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = sts.last_cand ? ST_OUT : ST_CAND;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_WRITE: cmd.wr    = 1'b1;
			ST_CAND:  cmd.cand  = 1'b1;
			ST_CLOAD: cmd.cload = 1'b1;
			ST_SCAN:  cmd.scan  = 1'b1;
			ST_OUT:   cmd.out_ld = !out_valid_q || m_tready;
			default: begin
				cmd      = '0;
				s_tready = 1'b0;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

FILE: rtl/core/swm_dp.sv
// Datapath for the sliding window median block: window RAM, ring pointer,
// rank counters and result register. Depends on swm_pkg and swm_ram.
module swm_dp import swm_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  swm_cmd_t          cmd,
	output swm_sts_t          sts,
	input  logic [DATA_W-1:0] sample,
	output logic [DATA_W-1:0] median
);

	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [CW-1:0] N_C  = CW'(WINDOW);
	localparam logic [IW-1:0] LAST = IW'(WINDOW - 1);
	// sorted positions of the two middle entries (equal for odd windows)
	localparam logic [CW-1:0] R_HI = CW'(WINDOW / 2);
	localparam logic [CW-1:0] R_LO = (WINDOW % 2 == 0) ? CW'(WINDOW / 2 - 1) : CW'(WINDOW / 2);

	logic [IW-1:0]     wpos_q;
	logic [CW-1:0]     fill_q;
	logic [IW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic [CW-1:0]     lt_q, le_q;
	logic              cmp_s1;
	logic [IW-1:0]     jidx_s1;
	logic [DATA_W-1:0] sample_q, cand_q, lo_q, hi_q, med_q;

	logic              issue, re;
	logic [IW-1:0]     raddr;
	logic [DATA_W-1:0] rdata, scan_val;
	logic              rank_upd;
	logic [DATA_W:0]   sum;

	swm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(WINDOW)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(wpos_q),
		.wdata(sample_q),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign issue = (cmd.cload || cmd.scan) && (j_q != N_C);
	assign re    = cmd.cand || issue;
	assign raddr = cmd.cand ? i_q : j_q[IW-1:0];

	// entries never written since reset read as zero
	assign scan_val = (CW'(jidx_s1) < fill_q) ? rdata : '0;

	assign sts.scan_done = (j_q == N_C) && !cmp_s1;
	assign sts.last_cand = (i_q == LAST);
	assign rank_upd      = cmd.scan && sts.scan_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			fill_q <= '0;
			i_q    <= '0;
			j_q    <= '0;
			lt_q   <= '0;
			le_q   <= '0;
			cmp_s1 <= 1'b0;
		end else begin
			if (cmd.wr) begin
				wpos_q <= (wpos_q == LAST) ? '0 : wpos_q + 1'b1;
				if (fill_q != N_C) begin
					fill_q <= fill_q + 1'b1;
				end
				i_q <= '0;
			end
			if (cmd.cand) begin
				j_q    <= '0;
				lt_q   <= '0;
				le_q   <= '0;
				cmp_s1 <= 1'b0;
			end else if (cmd.cload || cmd.scan) begin
				cmp_s1 <= issue;
				j_q    <= j_q + CW'(issue);
				if (cmp_s1) begin
					lt_q <= lt_q + CW'(scan_val < cand_q);
					le_q <= le_q + CW'(scan_val <= cand_q);
				end
			end
			if (rank_upd) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_q <= sample;
		end
		if (cmd.cload) begin
			cand_q <= (CW'(i_q) < fill_q) ? rdata : '0;
		end
		if (issue) begin
			jidx_s1 <= j_q[IW-1:0];
		end
		// candidate covers sorted positions lt .. le-1
		if (rank_upd && (lt_q <= R_LO) && (R_LO < le_q)) begin
			lo_q <= cand_q;
		end
		if (rank_upd && (lt_q <= R_HI) && (R_HI < le_q)) begin
			hi_q <= cand_q;
		end
		if (cmd.out_ld) begin
			med_q <= sum[DATA_W:1];
		end
	end

	assign sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign median = med_q;

endmodule

FILE: rtl/core/sliding_window_median.sv
// Sliding window median filter, top level. Each sample transfer overwrites the
// oldest of WINDOW stored samples; one median transfer follows per sample. The
// median is found by ranking: each window entry in turn is compared against all
// entries, one RAM read per cycle, through the single read port of the window RAM.
// A new sample is accepted only once the previous median has been loaded into
// the output register. Entries not yet written since reset count as zero through
// a fill counter, so reset needs no clearing pass. A finished result waits in an
// output register while the next sample is taken.
`include "sliding_window_median_defines.svh"
module sliding_window_median import swm_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [15:0] median
);

	swm_cmd_t cmd;
	swm_sts_t sts;

	swm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	swm_dp #(
		.WINDOW(WINDOW)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.sample(s_tdata),
		.median(m_tdata)
	);

	`SWM_ASSERT_HS(a_take_then_write, (s_tvalid && s_tready) |=> cmd.wr, "accepted sample not written")
	`SWM_ASSERT(a_load_sets_valid, cmd.out_ld |=> m_tvalid, "result loaded but not presented")
	`SWM_ASSERT(a_busy_blocks_input, (cmd.scan && sts.scan_done && sts.last_cand) |=> !s_tready, "input taken before result loaded")

endmodule

FILE: bench/sliding_window_median_tb.sv
`timescale 1ns / 1ps
// Testbench for sliding_window_median: drives sample transfers with random gaps,
// predicts each median from a private copy of the window and checks every result.
// Depends on swm_pkg and the sliding_window_median RTL.
module sliding_window_median_tb;
	import swm_pkg::*;

	localparam int WIN         = WINDOW_DEF;
	localparam int ITEM_CYCLES = WIN * (WIN + 3) + 3;
	localparam int IDLE_MAX    = 18;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	// private copy of the block's window and ring pointer
	logic [15:0] win_store [WIN];
	int          wr_pos;
	logic [15:0] median_q [$];
	logic [15:0] prev_sample;

	int send_idle_max;
	int sink_idle_max;
	int mismatches;
	int idle_cycles;

	sliding_window_median #(.WINDOW(WIN)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Write the sample over the oldest entry, then sort a copy and take the middle.
	function automatic logic [15:0] predict_median(input logic [15:0] sample);
		logic [15:0] srt [WIN];
		logic [15:0] key;
		logic [16:0] pair_sum;
		int i;
		int j;
		win_store[wr_pos] = sample;
		wr_pos = (wr_pos == WIN - 1) ? 0 : wr_pos + 1;
		srt = win_store;
		for (i = 1; i < WIN; i++) begin
			key = srt[i];
			j = i;
			while (j > 0 && srt[j - 1] > key) begin
				srt[j] = srt[j - 1];
				j--;
			end
			srt[j] = key;
		end
		if (WIN < 2)
			return srt[0];
		if (WIN % 2 != 0)
			return srt[WIN / 2];
		// 17-bit sum so two large middles do not wrap
		pair_sum = 17'(srt[WIN / 2 - 1]) + 17'(srt[WIN / 2]);
		return pair_sum[16:1];
	endfunction

	function automatic logic [15:0] random_sample();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			3: begin
				case ($urandom_range(0, 5))
					0: v = 16'h0000;
					1: v = 16'h0001;
					2: v = 16'h7FFF;
					3: v = 16'h8000;
					4: v = 16'hFFFE;
					default: v = 16'hFFFF;
				endcase
			end
			4: v = 16'($urandom_range(0, 3));           // many duplicates
			5: v = 16'hFFFF - 16'($urandom_range(0, 3));
			6: v = prev_sample + 16'($urandom_range(0, 2)) - 16'd1;  // slow ramp
			7: v = 16'h0001 << $urandom_range(0, 15);
			default: v = 16'($urandom_range(0, 16'hFFFF));
		endcase
		prev_sample = v;
		return v;
	endfunction

	function automatic void note_mismatch(input string what, input logic [15:0] exp_med,
			input logic [15:0] act_med);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected median %h, got %h", $realtime, what, exp_med, act_med);
	endfunction

	// Leaves tvalid high after the transfer so back-to-back items need no extra step.
	task automatic send_sample(input logic [15:0] sample);
		int gap;
		gap = $urandom_range(0, send_idle_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sample;
		do @(posedge clk); while (!s_tready);
		median_q.push_back(predict_median(sample));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (median_q.size() != 0) @(posedge clk);
	endtask

	// Fresh window: zeros from reset take part until overwritten; then extremes.
	task automatic test_fresh_window();
		logic [15:0] seq [22] = '{
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE,
			16'hFFFE, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF, 16'hA5A5, 16'h5A5A,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h1234, 16'h1234,
			16'h1234};
		foreach (seq[k])
			send_sample(seq[k]);
	endtask

	task automatic test_back_to_back(input int count);
		send_idle_max = 0;
		sink_idle_max = 0;
		repeat (count) send_sample(random_sample());
		send_idle_max = IDLE_MAX;
		sink_idle_max = IDLE_MAX;
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_sample(random_sample());
	endtask

	// Sender holds off until every median is back, then resumes.
	task automatic test_drain_pause(input int rounds);
		repeat (rounds) begin
			repeat ($urandom_range(1, 30)) send_sample(random_sample());
			wait_drained();
		end
	endtask

	// No send gaps; a result may wait in the output register.
	task automatic test_slow_sink(input int count);
		send_idle_max = 0;
		repeat (count) send_sample(random_sample());
		send_idle_max = IDLE_MAX;
	endtask

	// result side: random stalls, compare each transfer with the oldest prediction
	initial begin
		int stall;
		logic [15:0] exp_med;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, sink_idle_max);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (median_q.size() == 0) begin
				note_mismatch("result with nothing pending", 16'h0000, m_tdata);
			end else begin
				exp_med = median_q.pop_front();
				if (m_tdata !== exp_med)
					note_mismatch("median", exp_med, m_tdata);
			end
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		s_tvalid      <= 1'b0;
		s_tdata       <= '0;
		mismatches    = 0;
		wr_pos        = 0;
		prev_sample   = '0;
		send_idle_max = IDLE_MAX;
		sink_idle_max = IDLE_MAX;
		foreach (win_store[k])
			win_store[k] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fresh_window();
		test_back_to_back(100);
		test_random_mix(600);
		test_drain_pause(12);
		test_slow_sink(100);
		test_random_mix(200);

		wait_drained();
		repeat (ITEM_CYCLES + 20) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
